FILE: design/char_lcd_nibble_refresh_engine_assert.svh
// Assertion macros shared by the design files.
`ifndef CHAR_LCD_NIBBLE_REFRESH_ENGINE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_REFRESH_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset.
`define CLNRE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define CLNRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/clnre_pkg.sv
`default_nettype none
package clnre_pkg;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;

  localparam logic [2:0] REG_POWER   = 3'd0;
  localparam logic [2:0] REG_COMMAND = 3'd1;
  localparam logic [2:0] REG_FINAL   = 3'd2;
  localparam logic [2:0] REG_ENABLE  = 3'd3;
  localparam logic [2:0] REG_SETTLE  = 3'd4;

  localparam logic [15:0] POWER_WAIT_RST   = 16'd15000;
  localparam logic [15:0] COMMAND_WAIT_RST = 16'd4500;
  localparam logic [15:0] FINAL_WAIT_RST   = 16'd50;
  localparam logic [7:0]  ENABLE_WAIT_RST  = 8'd1;
  localparam logic [15:0] SETTLE_WAIT_RST  = 16'd50;

  localparam logic [2:0] INIT_DONE  = 3'd0;
  localparam logic [2:0] INIT_WAKE  = 3'd1;
  localparam logic [2:0] INIT_FOUR  = 3'd2;
  localparam logic [2:0] INIT_FUNC  = 3'd3;
  localparam logic [2:0] INIT_DISP  = 3'd4;
  localparam logic [2:0] INIT_ENTRY = 3'd5;
  localparam logic [2:0] INIT_FINAL = 3'd6;

  localparam logic [2:0] SEND_NIB    = 3'd0;
  localparam logic [2:0] SEND_RISE   = 3'd1;
  localparam logic [2:0] SEND_FALL   = 3'd2;
  localparam logic [2:0] SEND_SETTLE = 3'd3;
  localparam logic [2:0] SEND_IDLE   = 3'd4;

  localparam logic [16:0] TIMER_CAP = 17'h10000;

  localparam logic [7:0] LCD_WAKE_NIB  = 8'h30;
  localparam logic [7:0] LCD_FOUR_NIB  = 8'h20;
  localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LCD_ROW1_ADDR = 8'h40;
  localparam logic [7:0] LCD_SPACE     = 8'h20;

  localparam logic [2:0] WAKE_COUNT = 3'd3;
  localparam logic [2:0] FUNC_COUNT = 3'd6;

  typedef struct packed {
    logic [15:0] power_wait_us;
    logic [15:0] command_wait_us;
    logic [15:0] final_wait_us;
    logic [7:0]  enable_wait_us;
    logic [15:0] settle_wait_us;
  } cfg_t;

  typedef struct packed {
    logic       write_rejected;
    logic       refresh_busy;
    logic       init_done;
    logic [3:0] data_nibble;
    logic       enable_pin;
    logic       rs_pin;
  } result_t;

endpackage
`default_nettype wire

FILE: design/char_lcd_nibble_refresh_engine.sv
// A result beat is computed from the beat in the input register and registered when the result register can advance.
// Throughput: one beat per cycle unless out_tready stalls; the input and result registers each hold one beat.
// Reset (rst_n low, synchronous): waits to their defaults, power-up sequence restarted,
// a refresh pending and the text store reading as spaces until each entry is written.
`default_nettype none
module char_lcd_nibble_refresh_engine #(
  parameter int COLUMNS = 20,
  parameter int ROWS    = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // position[6:0], char_code[14:7], zero[15]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata,  // rs_pin[0], enable_pin[1], data_nibble[5:2],
                                       // init_done[6], refresh_busy[7], write_rejected[8]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);
  import clnre_pkg::*;

  `include "char_lcd_nibble_refresh_engine_assert.svh"

  localparam int STORE_SIZE = COLUMNS * ROWS;
  localparam int IDX_W      = $clog2(STORE_SIZE);

  cfg_t             cfg_r;
  logic             s1_valid_r;
  logic [1:0]       s1_cmd_r;
  logic [6:0]       s1_pos_r;
  logic [7:0]       s1_char_r;
  logic             out_valid_r;
  result_t          out_res_r;
  result_t          result_nxt;
  logic             adv;
  logic             step_en;
  logic             store_wr_en;
  logic [IDX_W-1:0] store_wr_addr;
  logic [IDX_W-1:0] store_rd_addr;
  logic [7:0]       store_rd_data;

  assign adv       = !out_valid_r || out_tready;
  assign step_en   = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_wait_us   <= POWER_WAIT_RST;
      cfg_r.command_wait_us <= COMMAND_WAIT_RST;
      cfg_r.final_wait_us   <= FINAL_WAIT_RST;
      cfg_r.enable_wait_us  <= ENABLE_WAIT_RST;
      cfg_r.settle_wait_us  <= SETTLE_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POWER:   cfg_r.power_wait_us   <= cfg_wdata;
        REG_COMMAND: cfg_r.command_wait_us <= cfg_wdata;
        REG_FINAL:   cfg_r.final_wait_us   <= cfg_wdata;
        REG_ENABLE:  cfg_r.enable_wait_us  <= cfg_wdata[7:0];
        REG_SETTLE:  cfg_r.settle_wait_us  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hold the input beat while the result register is stalled
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= in_tuser;
      s1_pos_r  <= in_tdata[6:0];
      s1_char_r <= in_tdata[14:7];
    end
    if (step_en) begin
      out_res_r <= result_nxt;
    end
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (step_en) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  clnre_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .IDX_W   (IDX_W)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .cmd           (s1_cmd_r),
    .position      (s1_pos_r),
    .cfg           (cfg_r),
    .store_rd_data (store_rd_data),
    .store_wr_en   (store_wr_en),
    .store_wr_addr (store_wr_addr),
    .store_rd_addr (store_rd_addr),
    .result_nxt    (result_nxt)
  );

  clnre_text_store #(
    .DEPTH (STORE_SIZE),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (store_wr_en),
    .wr_addr (store_wr_addr),
    .wr_data (s1_char_r),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r};

  `CLNRE_ASSERT_NEXT(a_step_shows, step_en, out_valid_r, "processed beat not presented")
  `CLNRE_ASSERT_NEXT(a_s1_hold, s1_valid_r && !adv, s1_valid_r && $stable(s1_pos_r) && $stable(s1_cmd_r), "stalled beat lost")
  `CLNRE_ASSERT_NEXT(a_out_hold, out_valid_r && !out_tready, out_valid_r && $stable(out_res_r), "stalled result lost")

endmodule
`default_nettype wire

FILE: design/clnre_text_store.sv
`default_nettype none
module clnre_text_store #(
  parameter int DEPTH = 80,
  parameter int IDX_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [7:0]       wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output      logic [7:0]       rd_data
);
  import clnre_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       mem_rd_r;
  logic             vld_rd_r;
  logic             byp_r;
  logic [7:0]       byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wr_data;
    if (!rst_n) begin
      vld_r    <= '0;
      vld_rd_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      vld_rd_r <= vld_r[rd_addr];
      byp_r    <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : (vld_rd_r ? mem_rd_r : LCD_SPACE);

endmodule
`default_nettype wire

FILE: design/clnre_core.sv
`default_nettype none
module clnre_core #(
  parameter int COLUMNS = 20,
  parameter int ROWS    = 4,
  parameter int IDX_W   = 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire logic [1:0]         cmd,
  input  wire logic [6:0]         position,
  input  wire clnre_pkg::cfg_t    cfg,
  input  wire logic [7:0]         store_rd_data,
  output      logic               store_wr_en,
  output      logic [IDX_W-1:0]   store_wr_addr,
  output      logic [IDX_W-1:0]   store_rd_addr,
  output      clnre_pkg::result_t result_nxt
);
  import clnre_pkg::*;

  `include "char_lcd_nibble_refresh_engine_assert.svh"

  localparam int STORE_SIZE = COLUMNS * ROWS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [1:0]       ROW_LAST = 2'(ROWS - 1);

  logic [2:0]       init_step_r, init_step_nxt;
  logic [2:0]       init_repeat_r, init_repeat_nxt;
  logic [16:0]      init_timer_r, init_timer_nxt;
  logic [2:0]       send_step_r, send_step_nxt;
  logic [16:0]      send_timer_r, send_timer_nxt;
  logic [7:0]       send_byte_r, send_byte_nxt;
  logic             second_due_r, second_due_nxt;
  logic             rs_r, rs_nxt;
  logic             en_r, en_nxt;
  logic [3:0]       nibble_r, nibble_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [1:0]       row_r, row_nxt;
  logic             streaming_r, streaming_nxt;
  logic             row_due_r, row_due_nxt;
  logic             pending_r, pending_nxt;
  logic             rejected;
  logic             row_sent;
  logic [7:0]       row_addr;

  always_comb begin
    unique case (row_r)
      2'd0:    row_addr = 8'h00;
      2'd1:    row_addr = LCD_ROW1_ADDR;
      2'd2:    row_addr = 8'(COLUMNS);
      default: row_addr = 8'(LCD_ROW1_ADDR + 8'(COLUMNS));
    endcase
  end

  always_comb begin
    init_step_nxt   = init_step_r;
    init_repeat_nxt = init_repeat_r;
    init_timer_nxt  = init_timer_r;
    send_step_nxt   = send_step_r;
    send_timer_nxt  = send_timer_r;
    send_byte_nxt   = send_byte_r;
    second_due_nxt  = second_due_r;
    rs_nxt          = rs_r;
    en_nxt          = en_r;
    nibble_nxt      = nibble_r;
    idx_nxt         = idx_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    streaming_nxt   = streaming_r;
    row_due_nxt     = row_due_r;
    pending_nxt     = pending_r;
    rejected        = 1'b0;
    store_wr_en     = 1'b0;
    row_sent        = 1'b0;
    if (step_en) begin
      unique case (cmd)
        CMD_TICK: begin
          if (init_timer_r != TIMER_CAP) init_timer_nxt = init_timer_r + 17'd1;
          if (send_timer_r != TIMER_CAP) send_timer_nxt = send_timer_r + 17'd1;

          unique case (init_step_r)
            INIT_WAKE: begin
              if (init_timer_nxt > 17'(cfg.power_wait_us)) begin
                init_timer_nxt = '0;
                second_due_nxt = 1'b0;
                send_byte_nxt  = LCD_WAKE_NIB;
                send_step_nxt  = SEND_NIB;
                rs_nxt         = 1'b0;
                if (init_repeat_r + 3'd1 >= WAKE_COUNT) begin
                  init_repeat_nxt = '0;
                  init_step_nxt   = INIT_FOUR;
                end else begin
                  init_repeat_nxt = init_repeat_r + 3'd1;
                end
              end
            end
            INIT_FOUR: begin
              if (init_timer_nxt > 17'(cfg.power_wait_us) && send_step_r == SEND_IDLE) begin
                init_timer_nxt  = '0;
                second_due_nxt  = 1'b0;
                send_byte_nxt   = LCD_FOUR_NIB;
                send_step_nxt   = SEND_NIB;
                rs_nxt          = 1'b0;
                init_repeat_nxt = '0;
                init_step_nxt   = INIT_FUNC;
              end
            end
            INIT_FUNC: begin
              if (init_timer_nxt > 17'(cfg.command_wait_us) && send_step_r == SEND_IDLE) begin
                init_timer_nxt = '0;
                second_due_nxt = 1'b1;
                send_byte_nxt  = LCD_FUNC_SET;
                send_step_nxt  = SEND_NIB;
                rs_nxt         = 1'b0;
                if (init_repeat_r + 3'd1 >= FUNC_COUNT) begin
                  init_repeat_nxt = '0;
                  init_step_nxt   = INIT_DISP;
                end else begin
                  init_repeat_nxt = init_repeat_r + 3'd1;
                end
              end
            end
            INIT_DISP: begin
              if (init_timer_nxt > 17'(cfg.command_wait_us) && send_step_r == SEND_IDLE) begin
                init_timer_nxt = '0;
                second_due_nxt = 1'b1;
                send_byte_nxt  = LCD_DISP_ON;
                send_step_nxt  = SEND_NIB;
                rs_nxt         = 1'b0;
                init_step_nxt  = INIT_ENTRY;
              end
            end
            INIT_ENTRY: begin
              if (init_timer_nxt > 17'(cfg.command_wait_us) && send_step_r == SEND_IDLE) begin
                init_timer_nxt = '0;
                second_due_nxt = 1'b1;
                send_byte_nxt  = LCD_ENTRY;
                send_step_nxt  = SEND_NIB;
                rs_nxt         = 1'b0;
                init_step_nxt  = INIT_FINAL;
              end
            end
            INIT_FINAL: begin
              if (init_timer_nxt > 17'(cfg.final_wait_us) && send_step_r == SEND_IDLE) begin
                init_timer_nxt = '0;
                init_step_nxt  = INIT_DONE;
              end
            end
            default: ;
          endcase

          if (send_step_nxt == SEND_IDLE && streaming_r && init_step_nxt == INIT_DONE) begin
            if (row_due_r && col_r == '0) begin
              row_due_nxt    = 1'b0;
              second_due_nxt = 1'b1;
              send_byte_nxt  = LCD_SET_DDRAM | row_addr;
              send_step_nxt  = SEND_NIB;
              rs_nxt         = 1'b0;
              row_sent       = 1'b1;
            end else begin
              second_due_nxt = 1'b1;
              send_byte_nxt  = store_rd_data;
              send_step_nxt  = SEND_NIB;
              rs_nxt         = 1'b1;
              row_due_nxt    = 1'b1;
              if (col_r == COL_LAST && row_r == ROW_LAST) begin
                streaming_nxt = 1'b0;
                idx_nxt       = '0;
                col_nxt       = '0;
                row_nxt       = '0;
              end else if (col_r == COL_LAST) begin
                idx_nxt = idx_r + IDX_W'(1);
                col_nxt = '0;
                row_nxt = row_r + 2'd1;
              end else begin
                idx_nxt = idx_r + IDX_W'(1);
                col_nxt = col_r + COL_W'(1);
              end
            end
          end
          if (!row_sent && pending_r && !streaming_nxt) begin
            pending_nxt   = 1'b0;
            streaming_nxt = 1'b1;
            idx_nxt       = '0;
            col_nxt       = '0;
            row_nxt       = '0;
            row_due_nxt   = 1'b1;
          end

          unique case (send_step_nxt)
            SEND_NIB: begin
              nibble_nxt     = send_byte_nxt[7:4];
              en_nxt         = 1'b0;
              send_step_nxt  = SEND_RISE;
              send_timer_nxt = '0;
            end
            SEND_RISE: begin
              if (send_timer_nxt > 17'(cfg.enable_wait_us)) begin
                send_timer_nxt = '0;
                send_step_nxt  = SEND_FALL;
                en_nxt         = 1'b1;
              end
            end
            SEND_FALL: begin
              if (send_timer_nxt > 17'(cfg.enable_wait_us)) begin
                send_timer_nxt = '0;
                send_step_nxt  = SEND_SETTLE;
                en_nxt         = 1'b0;
              end
            end
            SEND_SETTLE: begin
              if (send_timer_nxt > 17'(cfg.settle_wait_us)) begin
                send_timer_nxt = '0;
                if (second_due_nxt) begin
                  second_due_nxt = 1'b0;
                  send_byte_nxt  = {send_byte_nxt[3:0], 4'h0};
                  send_step_nxt  = SEND_NIB;
                end else begin
                  send_step_nxt = SEND_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
        CMD_WRITE: begin
          if (int'(position) < STORE_SIZE) store_wr_en = 1'b1;
          else rejected = 1'b1;
        end
        CMD_REFRESH: pending_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  assign store_wr_addr = IDX_W'(position);
  assign store_rd_addr = idx_nxt;

  assign result_nxt.write_rejected = rejected;
  assign result_nxt.refresh_busy   = pending_nxt || streaming_nxt;
  assign result_nxt.init_done      = (init_step_nxt == INIT_DONE);
  assign result_nxt.data_nibble    = nibble_nxt;
  assign result_nxt.enable_pin     = en_nxt;
  assign result_nxt.rs_pin         = rs_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_step_r   <= INIT_WAKE;
      init_repeat_r <= '0;
      init_timer_r  <= '0;
      send_step_r   <= SEND_IDLE;
      send_timer_r  <= '0;
      send_byte_r   <= '0;
      second_due_r  <= 1'b0;
      rs_r          <= 1'b0;
      en_r          <= 1'b0;
      nibble_r      <= '0;
      idx_r         <= '0;
      col_r         <= '0;
      row_r         <= '0;
      streaming_r   <= 1'b0;
      row_due_r     <= 1'b1;
      pending_r     <= 1'b1;
    end else begin
      init_step_r   <= init_step_nxt;
      init_repeat_r <= init_repeat_nxt;
      init_timer_r  <= init_timer_nxt;
      send_step_r   <= send_step_nxt;
      send_timer_r  <= send_timer_nxt;
      send_byte_r   <= send_byte_nxt;
      second_due_r  <= second_due_nxt;
      rs_r          <= rs_nxt;
      en_r          <= en_nxt;
      nibble_r      <= nibble_nxt;
      idx_r         <= idx_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      streaming_r   <= streaming_nxt;
      row_due_r     <= row_due_nxt;
      pending_r     <= pending_nxt;
    end
  end

  `CLNRE_ASSERT_IMPL(a_en_in_pulse, en_r, send_step_r == SEND_FALL, "enable high outside pulse")
  `CLNRE_ASSERT_IMPL(a_row_range, 1'b1, row_r <= ROW_LAST, "row beyond display")
  `CLNRE_ASSERT_IMPL(a_idle_index, !streaming_r, idx_r == '0 && col_r == '0 && row_r == '0, "index not cleared")

endmodule
`default_nettype wire
